// ===== rtl/brmt_pkg.sv =====
package brmt_pkg;

  // Default sizes of the bitmap and of one block.
  localparam int unsigned MaxBlocksDef      = 1024;
  localparam int unsigned MarkWordBitsDef   = 32;
  localparam int unsigned BlockSizeBytesDef = 4096;

  // Fixed field widths of the stream and configuration channels.
  localparam int unsigned ReqFieldW = 16;
  localparam int unsigned AddrW     = 33;
  localparam int unsigned LimitW    = 11;
  localparam int unsigned BaseW     = 32;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 40;

  localparam logic [LimitW-1:0] LimitRst = 11'd1024;
  localparam logic [BaseW-1:0]  BaseRst  = 32'd0;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBounds   = 2'd1,
    StMapped   = 2'd2,
    StUnmapped = 2'd3
  } status_e;

  typedef enum logic {
    ReqMap   = 1'b0,
    ReqUnmap = 1'b1
  } req_e;

  typedef enum logic {
    CfgBlockLimit = 1'b0,
    CfgDataBase   = 1'b1
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic start;
    logic setup;
    logic chk_step;
    logic restart;
    logic upd_step;
    logic load_out;
    logic clr_step;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic oob;
    logic zero_len;
    logic hit;
    logic walk_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/brmt_ram.sv =====
module brmt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/brmt_ctrl.sv =====
module brmt_ctrl
  import brmt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    SClear = 9'b000000001,
    SIdle  = 9'b000000010,
    SStart = 9'b000000100,
    SSetup = 9'b000001000,
    SRdChk = 9'b000010000,
    SChk   = 9'b000100000,
    SRdUpd = 9'b001000000,
    SUpd   = 9'b010000000,
    SFin   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      SClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
        if (in_valid_i) begin
          state_d = SStart;
        end
      end
      SStart: begin
        cmd_o.start = 1'b1;
        if (sts_i.oob || sts_i.zero_len) begin
          state_d = SFin;
        end else begin
          state_d = SSetup;
        end
      end
      SSetup: begin
        cmd_o.setup = 1'b1;
        state_d     = SRdChk;
      end
      SRdChk: begin
        state_d = SChk;
      end
      SChk: begin
        cmd_o.chk_step = 1'b1;
        if (sts_i.hit) begin
          state_d = SFin;
        end else if (sts_i.walk_last) begin
          cmd_o.restart = 1'b1;
          state_d       = SRdUpd;
        end else begin
          state_d = SRdChk;
        end
      end
      SRdUpd: begin
        state_d = SUpd;
      end
      SUpd: begin
        cmd_o.upd_step = 1'b1;
        if (sts_i.walk_last) begin
          state_d = SFin;
        end else begin
          state_d = SRdUpd;
        end
      end
      SFin: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule

// ===== rtl/brmt_dp.sv =====
module brmt_dp
  import brmt_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS       = MaxBlocksDef,
  parameter int unsigned MARK_WORD_BITS   = MarkWordBitsDef,
  parameter int unsigned BLOCK_SIZE_BYTES = BlockSizeBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                in_user_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [OutDataW-1:0] out_data_o,
  input  logic                cfg_valid_i,
  input  logic                cfg_index_i,
  input  logic [BaseW-1:0]    cfg_data_i
);

  localparam int unsigned MARK_WORDS = (MAX_BLOCKS + MARK_WORD_BITS - 1) / MARK_WORD_BITS;
  localparam int unsigned PTR_W      = (MARK_WORDS > 1) ? $clog2(MARK_WORDS) : 1;
  localparam int unsigned OFF_W      = $clog2(MARK_WORD_BITS);
  localparam int unsigned CNT_W      = $clog2(MARK_WORD_BITS + 1);
  localparam int unsigned HI_W       = CNT_W + 1;
  localparam int unsigned BS_W       = $clog2(BLOCK_SIZE_BYTES + 1);
  localparam int unsigned PROD_W     = ReqFieldW + BS_W;
  // Reciprocal for the block-to-word split; the estimate is at most one low.
  localparam int unsigned DIV_SHIFT  = 24;
  localparam logic [DIV_SHIFT-1:0] DIV_MUL =
    DIV_SHIFT'((64'd1 << DIV_SHIFT) / MARK_WORD_BITS);
  localparam int unsigned DPROD_W    = ReqFieldW + DIV_SHIFT;
  localparam logic [17:0] MAX_BLK18  = 18'(MAX_BLOCKS);
  localparam logic [PTR_W-1:0] LAST_WORD = PTR_W'(MARK_WORDS - 1);

  // Configuration registers.
  logic [LimitW-1:0] limit_q;
  logic [BaseW-1:0]  base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitRst;
      base_q  <= BaseRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgBlockLimit: limit_q <= cfg_data_i[LimitW-1:0];
        CfgDataBase:   base_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request registers.
  req_e                 req_type_q;
  logic [ReqFieldW-1:0] first_q;
  logic [ReqFieldW-1:0] len_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q <= req_e'(in_user_i);
      first_q    <= in_data_i[ReqFieldW-1:0];
      len_q      <= in_data_i[2*ReqFieldW-1:ReqFieldW];
    end
  end

  // Bounds check against the clamped limit.
  logic [17:0] end18, lim18;

  assign end18 = 18'(first_q) + 18'(len_q);
  assign lim18 = (18'(limit_q) > MAX_BLK18) ? MAX_BLK18 : 18'(limit_q);

  // Start: quotient estimate and address product.
  logic [DPROD_W-1:0]   dprod;
  logic [PROD_W-1:0]    aprod;
  logic [ReqFieldW-1:0] q_est_q;
  logic [AddrW-1:0]     addr_prod_q;
  status_e              status_q;

  assign dprod = DPROD_W'(first_q) * DPROD_W'(DIV_MUL);
  assign aprod = PROD_W'(first_q) * PROD_W'(BLOCK_SIZE_BYTES);

  // Setup: remainder and one correction step.
  logic [31:0]          qw_full;
  logic [16:0]          rem_raw, rem_fix;
  logic [ReqFieldW-1:0] q_fix;

  assign qw_full = 32'(q_est_q) * 32'(MARK_WORD_BITS);
  assign rem_raw = 17'(first_q) - 17'(qw_full);

  always_comb begin
    if (rem_raw >= 17'(MARK_WORD_BITS)) begin
      q_fix   = q_est_q + 16'd1;
      rem_fix = rem_raw - 17'(MARK_WORD_BITS);
    end else begin
      q_fix   = q_est_q;
      rem_fix = rem_raw;
    end
  end

  // Walk state.
  logic [PTR_W-1:0]     ptr_q, start_ptr_q;
  logic [OFF_W-1:0]     off_q, start_off_q;
  logic [ReqFieldW-1:0] remain_q;

  logic [CNT_W-1:0]          avail, take;
  logic [HI_W-1:0]           hi;
  logic [MARK_WORD_BITS-1:0] mask, rdata, new_word, wdata;
  logic                      walk_last, hit, we;

  assign avail     = CNT_W'(MARK_WORD_BITS) - CNT_W'(off_q);
  assign walk_last = 17'(remain_q) <= 17'(avail);
  assign take      = walk_last ? CNT_W'(remain_q) : avail;
  assign hi        = HI_W'(off_q) + HI_W'(take);

  always_comb begin
    for (int j = 0; j < MARK_WORD_BITS; j++) begin
      mask[j] = (HI_W'(j) >= HI_W'(off_q)) && (HI_W'(j) < hi);
    end
  end

  assign hit = (req_type_q == ReqUnmap) ? ((~rdata & mask) != '0) : ((rdata & mask) != '0);
  assign new_word = (req_type_q == ReqUnmap) ? (rdata & ~mask) : (rdata | mask);
  assign we       = cmd_i.upd_step | cmd_i.clr_step;
  assign wdata    = cmd_i.clr_step ? '0 : new_word;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      q_est_q     <= ReqFieldW'(dprod >> DIV_SHIFT);
      addr_prod_q <= AddrW'(aprod);
      status_q    <= (end18 > lim18) ? StBounds : StOk;
    end
    if (cmd_i.chk_step && hit) begin
      status_q <= (req_type_q == ReqUnmap) ? StUnmapped : StMapped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.setup) begin
      ptr_q <= PTR_W'(q_fix);
    end else if (cmd_i.restart) begin
      ptr_q <= start_ptr_q;
    end else if (cmd_i.clr_step || cmd_i.upd_step || (cmd_i.chk_step && !hit)) begin
      ptr_q <= ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      start_ptr_q <= PTR_W'(q_fix);
      start_off_q <= OFF_W'(rem_fix);
      off_q       <= OFF_W'(rem_fix);
      remain_q    <= len_q;
    end else if (cmd_i.restart) begin
      off_q    <= start_off_q;
      remain_q <= len_q;
    end else if (cmd_i.upd_step || (cmd_i.chk_step && !hit)) begin
      off_q    <= '0;
      remain_q <= remain_q - ReqFieldW'(take);
    end
  end

  brmt_ram #(
    .WIDTH(MARK_WORD_BITS),
    .DEPTH(MARK_WORDS)
  ) u_marks (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(ptr_q),
    .wdata_i(wdata),
    .raddr_i(ptr_q),
    .rdata_o(rdata)
  );

  // Output register.
  logic             out_valid_q;
  status_e          out_status_q;
  logic [AddrW-1:0] out_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      if (status_q == StOk && req_type_q == ReqMap) begin
        out_addr_q <= AddrW'(base_q) + addr_prod_q;
      end else begin
        out_addr_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {(OutDataW - AddrW - 2)'(0), out_addr_q, out_status_q};

  assign sts_o.clr_last  = ptr_q == LAST_WORD;
  assign sts_o.oob       = end18 > lim18;
  assign sts_o.zero_len  = len_q == '0;
  assign sts_o.hit       = hit;
  assign sts_o.walk_last = walk_last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/block_range_map_tracker_unit.sv =====
// Block range map tracker: keeps one mapped mark per buffer block and serves
// map and unmap requests on runs of consecutive blocks.
// Input stream: one transfer per request. tuser is the request type (map or
// unmap), tdata carries the first block and the run length.
// Output stream: exactly one transfer per request, carrying a status code and,
// for a successful map, the data base address plus first block times the
// block size; the address is zero for every other result.
// Configuration channel: index 0 writes the block limit, index 1 the data base
// address. It is always ready; write it only while the block is idle (the block itself does not enforce this).
// Flow: a request that fails the bounds check, or has a zero-length run,
// goes from the start state straight to the finish state. Otherwise the run is
// walked over the mark words it covers, twice (check, then update); each
// word is first read from the mark memory and then checked or updated.
// A failing check stops early and skips the update pass.
// One request is in flight at a time; the next one is taken as soon as the
// finished result sits in the output register.
// Reset: the mark memory is cleared one word per cycle, all MARK_WORDS words
// (32 by default), while the input side is held not ready.
// A stalled receiver holds the result in the output register; a further
// finished result waits inside the block until the register is free.
module block_range_map_tracker_unit
  import brmt_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS       = MaxBlocksDef,
  parameter int unsigned MARK_WORD_BITS   = MarkWordBitsDef,
  parameter int unsigned BLOCK_SIZE_BYTES = BlockSizeBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // first_block [15:0], run_length [31:16]
  input  logic                s_axis_tuser,  // req_type [0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // status [1:0], mapped_address [34:2], zero
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [BaseW-1:0]    cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Configuration writes complete in the cycle they are offered.
  assign cfg_ready_o = 1'b1;

  brmt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  brmt_dp #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MARK_WORD_BITS  (MARK_WORD_BITS),
    .BLOCK_SIZE_BYTES(BLOCK_SIZE_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // No request is taken while the mark memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> !s_axis_tready)
    else $error("input accepted during the clearing pass");

  // A new result appears only when the controller loads the output register.
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.load_out))
    else $error("output valid rose without a load");

  // Failed requests never carry an address.
  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] != StOk) |-> m_axis_tdata[34:2] == '0)
    else $error("failed request carries an address");

  // The memory is written only on update or clear steps, never together, and no request is accepted during an update.
  a_write_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.upd_step |-> !cmd.clr_step && !s_axis_tready)
    else $error("update step overlaps clearing or acceptance");

endmodule
